// ----- sv/aup_pkg.sv -----
// Shared types, codes and constants for the ASCII unsigned integer parser.
`timescale 1ns / 1ps

package aup_pkg;

   // Default sizes handed to the top level parameters.
   localparam int VALUE_BITS_DEF   = 32;
   localparam int WINDOW_BYTES_DEF = 4096;

   // Radix codes.
   localparam int          BASE_W    = 5;
   localparam logic [4:0]  BASE_AUTO = 5'd0;
   localparam logic [4:0]  BASE_OCT  = 5'd8;
   localparam logic [4:0]  BASE_DEC  = 5'd10;
   localparam logic [4:0]  BASE_HEX  = 5'd16;

   // Digit value given to a byte that is not a digit in any radix.
   localparam logic [4:0]  DIGIT_NONE = 5'd16;
   localparam logic [4:0]  DIGIT_TEN  = 5'd10;

   // Characters of interest.
   localparam logic [7:0]  CHAR_ZERO    = 8'h30;
   localparam logic [7:0]  CHAR_NINE    = 8'h39;
   localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
   localparam logic [7:0]  CHAR_LOWER_F = 8'h66;
   localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
   localparam logic [7:0]  CHAR_UPPER_F = 8'h46;
   localparam logic [7:0]  CHAR_LOWER_X = 8'h78;

   // Result status codes.
   localparam logic        STATUS_OK   = 1'b0;
   localparam logic        STATUS_FAIL = 1'b1;

   typedef enum logic [2:0] {
      PH_START  = 3'b001,
      PH_ZERO   = 3'b010,
      PH_DIGITS = 3'b100
   } phase_type;

   typedef struct packed {
      phase_type           phase;
      logic [BASE_W-1:0]   active_base;
      logic                wrap_flag;
   } ctl_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_available;
   } req_type;

   typedef struct packed {
      logic        parse_status;
      logic [31:0] parsed_value;
      logic [12:0] bytes_consumed;
      logic        overflowed;
   } rsp_type;

   typedef struct packed {
      logic [4:0] digit;
      logic       is_zero;
      logic       is_x;
   } char_class_type;

endpackage

// ----- sv/aup_char_class.sv -----
// Character classifier: digit value of a byte and the prefix characters.
`timescale 1ns / 1ps

module aup_char_class
   import aup_pkg::*;
(
   input  logic [7:0]     char_byte,
   output char_class_type char_class
);

   always_comb begin
      char_class.is_zero = (char_byte == CHAR_ZERO);
      char_class.is_x    = (char_byte == CHAR_LOWER_X);
      if (char_byte >= CHAR_ZERO && char_byte <= CHAR_NINE) begin
         char_class.digit = 5'(char_byte - CHAR_ZERO);
      end else if (char_byte >= CHAR_LOWER_A && char_byte <= CHAR_LOWER_F) begin
         char_class.digit = 5'(char_byte - CHAR_LOWER_A) + DIGIT_TEN;
      end else if (char_byte >= CHAR_UPPER_A && char_byte <= CHAR_UPPER_F) begin
         char_class.digit = 5'(char_byte - CHAR_UPPER_A) + DIGIT_TEN;
      end else begin
         char_class.digit = DIGIT_NONE;
      end
   end

endmodule

// ----- sv/aup_step.sv -----
// Next-state and result logic for one character of the number being parsed.
`timescale 1ns / 1ps

module aup_step
   import aup_pkg::*;
#(
   parameter int VALUE_BITS   = VALUE_BITS_DEF,
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
   input  req_type                             req,
   input  logic [BASE_W-1:0]                   number_base,
   input  ctl_type                             ctl,
   input  logic [VALUE_BITS-1:0]               acc,
   input  logic [$clog2(WINDOW_BYTES+1)-1:0]   cnt,
   output ctl_type                             ctl_next,
   output logic [VALUE_BITS-1:0]               acc_next,
   output logic [$clog2(WINDOW_BYTES+1)-1:0]   cnt_next,
   output logic                                emit,
   output rsp_type                             rsp
);

   localparam int CNT_W = $clog2(WINDOW_BYTES + 1);
   localparam int PW    = VALUE_BITS + BASE_W;
   localparam int AW    = (VALUE_BITS > 32) ? VALUE_BITS : 32;
   localparam int CW    = (CNT_W > 13) ? CNT_W : 13;
   localparam logic [CNT_W-1:0] WIN       = CNT_W'(WINDOW_BYTES);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);

   char_class_type    cls;
   logic [BASE_W-1:0] base_sel;
   logic              zero_start;
   logic              hex_prefix;
   logic              terminate;
   logic [PW-1:0]     prod;
   logic              wrap_new;
   logic [CNT_W-1:0]  cnt_inc;
   logic [AW-1:0]     acc_wide;
   logic [CW-1:0]     cnt_wide;

   aup_char_class u_char_class (
      .char_byte  (req.char_byte),
      .char_class (cls)
   );

   // Radix in force for this byte, and the two prefix cases of auto mode.
   always_comb begin
      zero_start = 1'b0;
      hex_prefix = 1'b0;
      unique case (ctl.phase)
         PH_START: begin
            if (number_base == BASE_AUTO) begin
               base_sel   = BASE_DEC;
               zero_start = cls.is_zero;
            end else if (number_base > BASE_HEX) begin
               base_sel = BASE_HEX;
            end else begin
               base_sel = number_base;
            end
         end
         PH_ZERO: begin
            base_sel   = BASE_OCT;
            hex_prefix = cls.is_x;
         end
         PH_DIGITS: begin
            if (ctl.active_base == BASE_AUTO || ctl.active_base > BASE_HEX) begin
               base_sel = BASE_HEX;
            end else begin
               base_sel = ctl.active_base;
            end
         end
         default: begin
            base_sel = BASE_HEX;
         end
      endcase
   end

   // Multiply-add in full width; anything above the value bits means a wrap.
   assign prod      = PW'(acc) * PW'(base_sel) + PW'(cls.digit);
   assign wrap_new  = ctl.wrap_flag | (prod[PW-1:VALUE_BITS] != '0);
   assign cnt_inc   = cnt + CNT_ONE;
   assign terminate = (cls.digit >= base_sel);
   assign acc_wide  = AW'(acc);
   assign cnt_wide  = CW'(cnt);

   always_comb begin
      ctl_next             = ctl;
      acc_next             = acc;
      cnt_next             = cnt;
      emit                 = 1'b0;
      rsp.parse_status     = STATUS_FAIL;
      rsp.parsed_value     = '0;
      rsp.bytes_consumed   = '0;
      rsp.overflowed       = 1'b0;

      if (zero_start) begin
         acc_next       = '0;
         cnt_next       = CNT_ONE;
         ctl_next.phase = PH_ZERO;
         emit           = req.last_available || (CNT_ONE >= WIN);
      end else if (hex_prefix) begin
         cnt_next             = CNT_TWO;
         ctl_next.phase       = PH_DIGITS;
         ctl_next.active_base = BASE_HEX;
         emit                 = req.last_available || (CNT_TWO >= WIN);
      end else if (terminate) begin
         emit               = 1'b1;
         rsp.parse_status   = STATUS_OK;
         rsp.parsed_value   = acc_wide[31:0];
         rsp.bytes_consumed = cnt_wide[12:0];
         rsp.overflowed     = ctl.wrap_flag;
      end else begin
         acc_next             = prod[VALUE_BITS-1:0];
         cnt_next             = cnt_inc;
         ctl_next.phase       = PH_DIGITS;
         ctl_next.active_base = base_sel;
         ctl_next.wrap_flag   = wrap_new;
         emit                 = req.last_available || (cnt_inc >= WIN);
      end

      // Any result ends the number.
      if (emit) begin
         ctl_next.phase       = PH_START;
         ctl_next.active_base = BASE_AUTO;
         ctl_next.wrap_flag   = 1'b0;
         acc_next             = '0;
         cnt_next             = '0;
      end
   end

endmodule

// ----- sv/ascii_unsigned_integer_parser.sv -----
// Top level of the streaming ASCII unsigned integer parser with radix detection.
`timescale 1ns / 1ps

// Channel    Direction  Handshake              Payload
// req_       in         req_valid / req_stall  req_data: char_byte, last_available
// rsp_       out        rsp_valid / rsp_stall  rsp_data: status, value, count, overflow
// csr_       in         csr_wr_en              csr_wr_data: number_base
//
// One request can be taken in every clock cycle unless the input side stalls. A request
// accepted at a rising edge waits in the input register; when it moves on, the character
// step updates the number state and, if the request ends a number, loads the result
// register, from which the result is offered. Reset clears the radix register,
// the number state and both valid flags. The input side stalls only while a result
// waits and the consumer stalls it; the held request then waits as well.

module ascii_unsigned_integer_parser
   import aup_pkg::*;
#(
   parameter int VALUE_BITS   = VALUE_BITS_DEF,
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [BASE_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(WINDOW_BYTES + 1);
   localparam logic [CNT_W-1:0] WIN = CNT_W'(WINDOW_BYTES);

   // Radix register; zero selects detection from the prefix.
   logic [BASE_W-1:0]     number_base_ff;

   // Input register.
   logic                  in_valid_ff, in_valid_in;
   req_type               in_req_ff;

   // Number state carried from one character to the next.
   ctl_type               ctl_ff, ctl_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   // Result register.
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_rsp_ff;

   logic                  advance;
   logic                  req_accept;
   logic                  step_emit;
   rsp_type               step_rsp;

   // The held request moves on whenever the result register is free or is being
   // emptied in this cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance ? step_emit : (out_valid_ff && rsp_stall);

   aup_step #(
      .VALUE_BITS   (VALUE_BITS),
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_step (
      .req         (in_req_ff),
      .number_base (number_base_ff),
      .ctl         (ctl_ff),
      .acc         (acc_ff),
      .cnt         (cnt_ff),
      .ctl_next    (ctl_in),
      .acc_next    (acc_in),
      .cnt_next    (cnt_in),
      .emit        (step_emit),
      .rsp         (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= BASE_AUTO;
      end else if (csr_wr_en) begin
         number_base_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.phase       <= PH_START;
         ctl_ff.active_base <= BASE_AUTO;
         ctl_ff.wrap_flag   <= 1'b0;
         acc_ff             <= '0;
         cnt_ff             <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_emit) begin
         out_rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

   // The input side is only ever held back by a waiting, stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_valid_ff && rsp_stall))
      else $error("input stalled without a stalled result");

   // A failed parse reports no value, no count and no overflow.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.parse_status == STATUS_FAIL) |->
      (rsp_data.parsed_value == '0 && rsp_data.bytes_consumed == '0 &&
       !rsp_data.overflowed))
      else $error("fail result carries data");

   // Every result ends the number and the next character starts afresh.
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && step_emit) |=>
      (ctl_ff.phase == PH_START && cnt_ff == '0 && acc_ff == '0 && !ctl_ff.wrap_flag))
      else $error("number state not cleared after a result");

   // The byte count never rests at the window size.
   a_count_window: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < WIN)
      else $error("byte count reached the window size");

   // After a lone leading zero exactly one byte has been counted and the value is zero.
   a_zero_phase: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.phase == PH_ZERO) |-> (cnt_ff == CNT_W'(1) && acc_ff == '0))
      else $error("leading zero state inconsistent");

endmodule

// ----- tb/sv/ascii_unsigned_integer_parser_tb.sv -----
// Self-checking testbench for the streaming ASCII unsigned integer parser.
`timescale 1ns / 1ps

// The bench has four parts.
// - The request side offers one character per request. It runs in bursts of
//   random length with random gaps between them.
// - The response side stalls on a pattern of its own. When asked, it holds
//   off for a long stretch so that the parser fills up and stalls its input.
// - A predictor tracks the number being parsed. It uses its own copy of the
//   radix register, and it queues the result that each accepted request
//   should produce.
// - A checker compares each accepted response, field by field, with the
//   oldest queued expectation.
// Handshakes are sampled on the falling edge, when every signal has settled.
// All inputs change on the rising edge.

module ascii_unsigned_integer_parser_tb;
   import aup_pkg::*;

   localparam int HALF_PERIOD     = 5;
   localparam int SETTLE_CYCLES   = 8;
   localparam int LONG_HOLD       = 120;
   localparam int PRINT_LIMIT     = 100;
   localparam int RANDOM_PER_BASE = 180;
   localparam int TIMEOUT_NS      = 10_000_000;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_type;

   // One row of the directed table. Where fixed is set, the result is typed in by hand.
   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic [7:0]        char_byte;
      logic              last;
      logic              fixed;
      rsp_type           result;
   } script_row_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   req_type           req_data    = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   rsp_type           rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [BASE_W-1:0] csr_wr_data = '0;

   // Predictor state: the number in progress and the radix register as last written.
   phase_type         num_phase = PH_START;
   logic [31:0]       num_acc   = '0;
   logic [BASE_W-1:0] num_radix = '0;
   logic [12:0]       num_count = '0;
   logic              num_wrap  = 1'b0;
   logic [BASE_W-1:0] base_reg  = BASE_AUTO;

   rsp_type        parse_results_due[$];
   script_row_type directed_rows[$];
   int             error_count = 0;
   int             sent_count  = 0;
   int             burst_left  = 0;

   // The stimulus process flips hold_toggle to ask the response side for a long stall.
   logic           hold_toggle = 1'b0;
   logic           hold_seen   = 1'b0;
   int             hold_left   = 0;
   int             mode_left   = 0;
   stall_kind_type stall_mode  = STALL_NONE;

   ascii_unsigned_integer_parser u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic rsp_type make_result(input logic status, input logic [31:0] value,
                                           input logic [12:0] count, input logic wrapped);
      rsp_type r;
      r.parse_status   = status;
      r.parsed_value   = value;
      r.bytes_consumed = count;
      r.overflowed     = wrapped;
      return r;
   endfunction

   // Digit value of a character in any radix up to 16; DIGIT_NONE for anything else.
   function automatic logic [4:0] char_digit(input logic [7:0] c);
      logic [7:0] offset;
      if (c >= CHAR_ZERO && c <= CHAR_NINE)
         offset = c - CHAR_ZERO;
      else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
         offset = c - CHAR_LOWER_A + 8'(DIGIT_TEN);
      else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
         offset = c - CHAR_UPPER_A + 8'(DIGIT_TEN);
      else
         offset = 8'(DIGIT_NONE);
      return offset[4:0];
   endfunction

   function automatic logic [7:0] digit_char(input int value);
      if (value < 10)
         return 8'(int'(CHAR_ZERO) + value);
      if ($urandom_range(0, 1) == 0)
         return 8'(int'(CHAR_LOWER_A) + value - 10);
      return 8'(int'(CHAR_UPPER_A) + value - 10);
   endfunction

   function automatic void restart_number();
      num_phase = PH_START;
      num_acc   = '0;
      num_radix = '0;
      num_count = '0;
      num_wrap  = 1'b0;
   endfunction

   // The number is abandoned when the data runs out or the text window is full.
   function automatic bit window_closed(input logic last);
      return last || num_count >= WINDOW_BYTES_DEF;
   endfunction

   // A digit below the radix extends the number; any other byte terminates it.
   function automatic bit absorb_digit(input req_type r, output rsp_type res);
      logic [4:0]  digit;
      logic [63:0] grown;
      res   = '0;
      digit = char_digit(r.char_byte);
      if (digit >= num_radix) begin
         res = make_result(STATUS_OK, num_acc, num_count, num_wrap);
         restart_number();
         return 1'b1;
      end
      grown = 64'(num_acc) * 64'(num_radix) + 64'(digit);
      if (grown[63:32] != 0)
         num_wrap = 1'b1;
      num_acc   = grown[31:0];
      num_count = num_count + 13'd1;
      num_phase = PH_DIGITS;
      if (window_closed(r.last_available)) begin
         res = make_result(STATUS_FAIL, 32'd0, 13'd0, 1'b0);
         restart_number();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Steps the predictor by one request. It returns 1 when the request completes a result.
   function automatic bit parse_char(input req_type r, output rsp_type res);
      res = '0;
      if (num_phase == PH_START) begin
         if (base_reg == BASE_AUTO) begin
            // A leading zero may be the start of a hex prefix, so it is held back.
            if (r.char_byte == CHAR_ZERO) begin
               num_acc   = '0;
               num_count = 13'd1;
               num_phase = PH_ZERO;
               if (window_closed(r.last_available)) begin
                  res = make_result(STATUS_FAIL, 32'd0, 13'd0, 1'b0);
                  restart_number();
                  return 1'b1;
               end
               return 1'b0;
            end
            num_radix = BASE_DEC;
         end else begin
            num_radix = (base_reg > BASE_HEX) ? BASE_HEX : base_reg;
         end
      end else if (num_phase == PH_ZERO) begin
         if (r.char_byte == CHAR_LOWER_X) begin
            num_radix = BASE_HEX;
            num_count = 13'd2;
            num_phase = PH_DIGITS;
            if (window_closed(r.last_available)) begin
               res = make_result(STATUS_FAIL, 32'd0, 13'd0, 1'b0);
               restart_number();
               return 1'b1;
            end
            return 1'b0;
         end
         num_radix = BASE_OCT;
      end else if (num_radix == BASE_AUTO || num_radix > BASE_HEX) begin
         num_radix = BASE_HEX;
      end
      return absorb_digit(r, res);
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_LIMIT)
         $display("MISMATCH at %0t ns: %s", $time, what);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   // Must be called just after a rising edge. The task returns just after the edge
   // at which the request is taken, and valid is left high for the next request.
   task automatic offer_request(input logic [7:0] ch, input logic last,
                                input logic fixed, input rsp_type fixed_rsp);
      req_type r;
      rsp_type res;
      bit      got;
      bit      taken;
      r.char_byte      = ch;
      r.last_available = last;
      req_valid <= 1'b1;
      req_data  <= r;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = (req_stall === 1'b0);
         if (taken) begin
            sent_count++;
            got = parse_char(r, res);
            if (fixed)
               parse_results_due.push_back(fixed_rsp);
            else if (got)
               parse_results_due.push_back(res);
         end
         @(posedge clock);
      end
   endtask

   // Runs the sender in bursts. At the end of each burst it may drop valid for a random gap.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_char(input logic [7:0] ch, input logic last);
      offer_request(ch, last, 1'b0, '0);
      pace_sender();
   endtask

   // Waits until every expected result has arrived. It then allows for a request
   // still in the pipeline that completes no number.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (parse_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_base(input logic [BASE_W-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      base_reg = value;
   endtask

   // Sends one well-formed number in the current radix: an optional prefix, digits
   // and a terminator. Now and then one byte is marked as the last data. The
   // bytes after it are then dropped.
   task automatic send_number();
      logic [7:0] text[$];
      logic [7:0] term;
      int         radix;
      int         min_digits;
      int         digits;
      int         stop_at;
      bit         lead_nonzero;
      text         = {};
      min_digits   = 1;
      lead_nonzero = 1'b0;
      if (base_reg == BASE_AUTO) begin
         case ($urandom_range(0, 2))
            0: begin
               text.push_back(CHAR_ZERO);
               text.push_back(CHAR_LOWER_X);
               radix      = 16;
               min_digits = 0;
            end
            1: begin
               text.push_back(CHAR_ZERO);
               radix      = 8;
               min_digits = 0;
            end
            default: begin
               radix        = 10;
               lead_nonzero = 1'b1;
            end
         endcase
      end else begin
         radix = (base_reg > BASE_HEX) ? 16 : int'(base_reg);
      end
      // Mostly short numbers. A few are long enough to wrap past 32 bits.
      digits = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                           : $urandom_range(min_digits, 6);
      for (int i = 0; i < digits; i++) begin
         if (i == 0 && lead_nonzero)
            text.push_back(digit_char($urandom_range(1, 9)));
         else
            text.push_back(digit_char($urandom_range(0, radix - 1)));
      end
      // In auto mode an 'x' after a lone zero would become a prefix, so it is kept out.
      do
         term = 8'($urandom_range(0, 255));
      while (char_digit(term) < radix || (base_reg == BASE_AUTO && term == CHAR_LOWER_X));
      text.push_back(term);
      stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, text.size() - 1) : -1;
      foreach (text[i]) begin
         send_char(text[i], i == stop_at);
         if (i == stop_at)
            break;
      end
   endtask

   function automatic void add_row(input logic [BASE_W-1:0] base, input logic [7:0] ch,
                                   input logic last, input logic fixed, input rsp_type res);
      script_row_type row;
      row.base      = base;
      row.char_byte = ch;
      row.last      = last;
      row.fixed     = fixed;
      row.result    = res;
      directed_rows.push_back(row);
   endfunction

   // Response side: a long hold when asked, otherwise stretches of differing stall patterns.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode_left  = $urandom_range(16, 96);
               stall_mode = stall_kind_type'($urandom_range(0, 3));
            end
            mode_left = mode_left - 1;
            case (stall_mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 7) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
               default:     rsp_stall <= ((mode_left % 10) < 4);
            endcase
         end
      end
   end

   // A response is taken at the next rising edge if valid is high and stall is low now.
   always @(negedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (parse_results_due.size() == 0) begin
            report_mismatch($sformatf("result with none expected: value %0h count %0d",
                                      rsp_data.parsed_value, rsp_data.bytes_consumed));
         end else begin
            want = parse_results_due.pop_front();
            compare_field("parse_status", 32'(rsp_data.parse_status),
                          32'(want.parse_status));
            compare_field("parsed_value", rsp_data.parsed_value, want.parsed_value);
            compare_field("bytes_consumed", 32'(rsp_data.bytes_consumed),
                          32'(want.bytes_consumed));
            compare_field("overflowed", 32'(rsp_data.overflowed), 32'(want.overflowed));
         end
      end
   end

   initial begin : stimulus
      logic [BASE_W-1:0] base_plan[$];
      int                phase_end;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table. The radix stays at its reset value (auto) until the rows ask
      // for another.
      // A non-digit first byte gives an empty number.
      add_row(BASE_AUTO, 8'h00, 1'b0, 1'b1, make_result(STATUS_OK, 32'd0, 13'd0, 1'b0));
      // A lone zero counts one byte.
      add_row(BASE_AUTO, CHAR_ZERO, 1'b0, 1'b0, '0);
      add_row(BASE_AUTO, 8'h20, 1'b0, 1'b1, make_result(STATUS_OK, 32'd0, 13'd1, 1'b0));
      // A hex prefix with no digits after it counts two bytes.
      add_row(BASE_AUTO, CHAR_ZERO, 1'b0, 1'b0, '0);
      add_row(BASE_AUTO, CHAR_LOWER_X, 1'b0, 1'b0, '0);
      add_row(BASE_AUTO, 8'h67, 1'b0, 1'b1, make_result(STATUS_OK, 32'd0, 13'd2, 1'b0));
      // Hex digits, ended by the top byte value.
      add_row(BASE_AUTO, CHAR_ZERO, 1'b0, 1'b0, '0);
      add_row(BASE_AUTO, CHAR_LOWER_X, 1'b0, 1'b0, '0);
      add_row(BASE_AUTO, CHAR_UPPER_F, 1'b0, 1'b0, '0);
      add_row(BASE_AUTO, 8'hFF, 1'b0, 1'b0, '0);
      // In decimal a letter digit ends the number.
      add_row(BASE_AUTO, CHAR_NINE, 1'b0, 1'b0, '0);
      add_row(BASE_AUTO, CHAR_LOWER_A, 1'b0, 1'b0, '0);
      // In octal an 8 ends the number.
      add_row(BASE_AUTO, CHAR_ZERO, 1'b0, 1'b0, '0);
      add_row(BASE_AUTO, 8'h38, 1'b0, 1'b0, '0);
      // The data runs out on a prefix byte or on a digit.
      add_row(BASE_AUTO, CHAR_ZERO, 1'b1, 1'b1,
              make_result(STATUS_FAIL, 32'd0, 13'd0, 1'b0));
      add_row(BASE_AUTO, CHAR_ZERO, 1'b0, 1'b0, '0);
      add_row(BASE_AUTO, CHAR_LOWER_X, 1'b1, 1'b1,
              make_result(STATUS_FAIL, 32'd0, 13'd0, 1'b0));
      add_row(BASE_AUTO, 8'h35, 1'b1, 1'b1, make_result(STATUS_FAIL, 32'd0, 13'd0, 1'b0));
      // In radix one only zero is a digit.
      add_row(5'd1, CHAR_ZERO, 1'b0, 1'b0, '0);
      add_row(5'd1, CHAR_ZERO, 1'b0, 1'b0, '0);
      add_row(5'd1, 8'h32, 1'b0, 1'b0, '0);
      // Any radix above sixteen acts as hex.
      add_row(5'd31, CHAR_LOWER_F, 1'b0, 1'b0, '0);
      add_row(5'd31, 8'h67, 1'b0, 1'b0, '0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].base != base_reg)
            set_base(directed_rows[i].base);
         offer_request(directed_rows[i].char_byte, directed_rows[i].last,
                       directed_rows[i].fixed, directed_rows[i].result);
         pace_sender();
      end

      // Random part: one stretch of numbers and noise for each radix setting.
      base_plan = '{BASE_AUTO, BASE_HEX, BASE_DEC, 5'd2, BASE_OCT, 5'd1, 5'd17, 5'd31,
                    BASE_AUTO, 5'd3};
      base_plan.push_back(5'($urandom_range(0, 31)));
      foreach (base_plan[p]) begin
         set_base(base_plan[p]);
         if (p == 2) begin
            // The response side holds off while requests keep coming with no gaps.
            hold_toggle <= ~hold_toggle;
            repeat (40)
               offer_request(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0,
                             1'b0, '0);
         end
         phase_end = sent_count + RANDOM_PER_BASE;
         while (sent_count < phase_end) begin
            if ($urandom_range(0, 9) < 8)
               send_number();
            else
               send_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
         end
      end

      drain_results();
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Test completed with failures");
      $finish;
   end

endmodule
